>>> rtl/core/dcfp_pkg.sv
// ----------------------------------------------------------------------------
// dcfp_pkg
// Shared types and constants for the drive command frame parser.
// ----------------------------------------------------------------------------
package dcfp_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Frame kinds.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_MOTOR  = 2'd1;
  localparam logic [1:0] KIND_CAMERA = 2'd2;

  // Sign byte classification carried with a command.
  localparam logic [1:0] SIGN_KEEP  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Channel numbers.
  localparam logic [1:0] CH_RIGHT = 2'd0;
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_PAN   = 2'd2;
  localparam logic [1:0] CH_TILT  = 2'd3;

  localparam logic [2:0] POS_MAX       = 3'd7;
  localparam logic [2:0] POS_CMD_READY = 3'd4;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_ONE   = 8'h31;
  localparam logic [7:0] ASCII_TWO   = 8'h32;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_R     = 8'h52;
  localparam logic [7:0] ASCII_L     = 8'h4C;
  localparam logic [7:0] ASCII_X     = 8'h58;
  localparam logic [7:0] ASCII_Y     = 8'h59;

  // '0' * 111, the digit offset folded into one subtraction.
  localparam logic [15:0] DIGIT_OFFSET = 16'd5328;

  localparam logic [15:0] MOTOR_LIMIT  = 16'd1000;
  localparam logic [15:0] CAMERA_LIMIT = 16'd10000;

  typedef struct packed {
    logic [1:0]  channel;
    logic [1:0]  sign;
    logic [15:0] value;
  } cmd_t;

endpackage

>>> rtl/core/drive_command_frame_parser.sv
// ----------------------------------------------------------------------------
// drive_command_frame_parser
// Parses ASCII motor and camera command frames into channel commands.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle while in_stall is low. A completed
// command is written into the command queue, and from the queue it is loaded
// into the output register. While the output is stalled, completed commands
// collect in a queue of QUEUE_DEPTH entries; in_stall rises only when that
// queue is full, so with an output that is never stalled the sustained rate
// is one byte every cycle.
module drive_command_frame_parser #(
  parameter int QUEUE_DEPTH = dcfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  channel,
  output logic        direction,
  output logic [13:0] magnitude
);
  import dcfp_pkg::*;

  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t push_entry;
  cmd_t head;

  assign in_stall = full;

  dcfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .frame_start (frame_start),
    .push        (push),
    .push_entry  (push_entry)
  );

  dcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  dcfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .direction (direction),
    .magnitude (magnitude)
  );

endmodule

>>> rtl/core/dcfp_front.sv
// ----------------------------------------------------------------------------
// dcfp_front
// Accepts frame bytes, tracks frame kind and position, and emits one
// classified command when the fifth byte of a command arrives.
// ----------------------------------------------------------------------------
module dcfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    byte_value,
  input  logic          frame_start,
  output logic          push,
  output dcfp_pkg::cmd_t push_entry
);
  import dcfp_pkg::*;

  logic [1:0] frame_kind;
  logic [2:0] position_count;
  logic [7:0] byte_window [4];

  logic       accept;
  logic       cmd_hit;
  logic [1:0] cmd_channel;
  logic [7:0] letter;
  logic [7:0] sign_byte;

  assign accept    = in_valid && !in_stall;
  assign letter    = byte_window[3];
  assign sign_byte = byte_window[2];

  always_comb begin
    cmd_hit     = 1'b0;
    cmd_channel = CH_RIGHT;
    if (frame_kind == KIND_MOTOR) begin
      if (letter == ASCII_R) begin
        cmd_hit     = 1'b1;
        cmd_channel = CH_RIGHT;
      end else if (letter == ASCII_L) begin
        cmd_hit     = 1'b1;
        cmd_channel = CH_LEFT;
      end
    end else if (frame_kind == KIND_CAMERA) begin
      if (letter == ASCII_X) begin
        cmd_hit     = 1'b1;
        cmd_channel = CH_PAN;
      end else if (letter == ASCII_Y) begin
        cmd_hit     = 1'b1;
        cmd_channel = CH_TILT;
      end
    end
  end

  always_comb begin
    push_entry.channel = cmd_channel;
    if (sign_byte == ASCII_PLUS) begin
      push_entry.sign = SIGN_PLUS;
    end else if (sign_byte == ASCII_MINUS) begin
      push_entry.sign = SIGN_MINUS;
    end else begin
      push_entry.sign = SIGN_KEEP;
    end
    // Three digit bytes to a 16-bit wrapping value.
    push_entry.value = 16'(byte_window[1]) * 16'd100 + 16'(byte_window[0]) * 16'd10
                     + 16'(byte_value) - DIGIT_OFFSET;
  end

  // The fifth byte of a command brings the count to at least five.
  assign push = accept && !frame_start && (position_count >= POS_CMD_READY) && cmd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind     <= KIND_NONE;
      position_count <= '0;
      for (int i = 0; i < 4; i++) begin
        byte_window[i] <= '0;
      end
    end else if (accept) begin
      if (frame_start) begin
        position_count <= '0;
        if (byte_value == ASCII_ONE) begin
          frame_kind <= KIND_MOTOR;
        end else if (byte_value == ASCII_TWO) begin
          frame_kind <= KIND_CAMERA;
        end else begin
          frame_kind <= KIND_NONE;
        end
      end else if (position_count < POS_MAX) begin
        position_count <= position_count + 3'd1;
      end
      byte_window[3] <= byte_window[2];
      byte_window[2] <= byte_window[1];
      byte_window[1] <= byte_window[0];
      byte_window[0] <= byte_value;
    end
  end

endmodule

>>> rtl/core/dcfp_queue.sv
// ----------------------------------------------------------------------------
// dcfp_queue
// Small command queue between the byte front end and the command executor.
// ----------------------------------------------------------------------------
module dcfp_queue #(
  parameter int DEPTH = dcfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcfp_pkg::cmd_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dcfp_pkg::cmd_t head
);
  import dcfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/dcfp_back.sv
// ----------------------------------------------------------------------------
// dcfp_back
// Executes queued commands: updates the kept channel direction, scales motor
// values, range-checks the value, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dcfp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  dcfp_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     channel,
  output logic           direction,
  output logic [13:0]    magnitude
);
  import dcfp_pkg::*;

  logic [3:0]  channel_direction;
  logic        is_motor;
  logic        dir_next;
  logic [15:0] scaled;
  logic [15:0] val;
  logic [15:0] limit;
  logic [13:0] mag_next;

  assign pop      = !empty && (!out_valid || !out_stall);
  assign is_motor = !head.channel[1];

  always_comb begin
    dir_next = channel_direction[head.channel];
    // Motor: plus clears, minus sets. Camera: the meaning is inverted.
    case (head.sign)
      SIGN_PLUS:  dir_next = !is_motor;
      SIGN_MINUS: dir_next = is_motor;
      default:    dir_next = channel_direction[head.channel];
    endcase
  end

  always_comb begin
    // Times ten as 8v + 2v, wrapping at 16 bits.
    scaled   = {head.value[12:0], 3'b000} + {head.value[14:0], 1'b0};
    val      = is_motor ? scaled : head.value;
    limit    = is_motor ? MOTOR_LIMIT : CAMERA_LIMIT;
    mag_next = ((val != '0) && (val <= limit)) ? 14'(val - 16'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      channel_direction <= '0;
    end else begin
      if (pop) begin
        out_valid                       <= 1'b1;
        channel_direction[head.channel] <= dir_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      channel   <= head.channel;
      direction <= dir_next;
      magnitude <= mag_next;
    end
  end

endmodule

>>> rtl/core/dcfp_checker.sv
// ----------------------------------------------------------------------------
// dcfp_checker
// Port-level checks for the drive command frame parser.
// ----------------------------------------------------------------------------
module dcfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  channel,
  input logic        direction,
  input logic [13:0] magnitude
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel) && $stable(direction)
      && $stable(magnitude))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // Motor magnitudes stay below the duty limit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !channel[1] |-> magnitude <= 14'd999)
    else $error("motor magnitude out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= 14'd9999)
    else $error("magnitude out of range");

endmodule

bind drive_command_frame_parser dcfp_checker u_dcfp_checker (.*);
